// ===== sv/tstt_pkg.sv =====
`default_nettype none
package tstt_pkg;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  localparam int SEQ_W = 32;
  localparam int LEN_W = 16;
  localparam int END_W = 33;
  localparam int TRAIN_CNT_OUT_W = 5;
  localparam int SEG_CNT_OUT_W = 7;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_FULL,
    OP_INS_EMPTY,
    OP_RD_LAST,
    OP_EXT_LAST,
    OP_APPEND,
    OP_SCAN_START,
    OP_SCAN_NEXT,
    OP_JOIN_BOTH,
    OP_JOIN_PREV,
    OP_JOIN_NEXT,
    OP_TINS_START,
    OP_TINS_READ,
    OP_TINS_WRITE,
    OP_TINS_FIN,
    OP_TDEL_READ,
    OP_TDEL_WRITE,
    OP_TDEL_FIN,
    OP_SINS_READ,
    OP_SINS_WRITE,
    OP_SINS_FIN,
    OP_REM_EMPTY,
    OP_REM_RD,
    OP_REM_UPD,
    OP_REM_FIRST,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic is_remove;
    logic len_zero;
    logic trains_zero;
    logic segs_full;
    logic trains_full;
    logic a_eq_last;
    logic a_gt_last;
    logic overlap;
    logic below;
    logic scan_last;
    logic join_prev;
    logic join_next;
    logic tdel_done;
    logic tins_done;
    logic sins_done;
    logic rem_empty;
    logic rem_del;
    logic rem_last;
  } dp_status_t;

endpackage
`default_nettype wire

// ===== sv/tstt_datapath.sv =====
`default_nettype none
module tstt_datapath
  import tstt_pkg::*;
#(
  parameter int MAX_SEGMENTS = 64,
  parameter int MAX_TRAINS = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire dp_cmd_t                    cmd,
  output dp_status_t                      status,
  input  wire logic                       in_command,
  input  wire logic [SEQ_W-1:0]           in_seg_start,
  input  wire logic [LEN_W-1:0]           in_seg_length,
  output logic                            out_ok,
  output logic [END_W-1:0]                out_list_first,
  output logic [END_W-1:0]                out_list_last,
  output logic [TRAIN_CNT_OUT_W-1:0]      out_train_count,
  output logic [SEG_CNT_OUT_W-1:0]        out_segment_count,
  output logic                            out_full_res
);

  localparam int SIW = $clog2(MAX_SEGMENTS);
  localparam int SCW = $clog2(MAX_SEGMENTS + 1);
  localparam int TIW = (MAX_TRAINS > 1) ? $clog2(MAX_TRAINS) : 1;
  localparam int TCW = $clog2(MAX_TRAINS + 1);

  // circular buffer address: head plus logical offset
  function automatic logic [TIW-1:0] tphys(input logic [TIW-1:0] h, input int k);
    int s;
    s = int'(h) + k;
    if (s >= MAX_TRAINS) s = s - MAX_TRAINS;
    return TIW'(s);
  endfunction

  function automatic logic [SIW-1:0] sphys(input logic [SIW-1:0] h, input int k);
    int s;
    s = int'(h) + k;
    if (s >= MAX_SEGMENTS) s = s - MAX_SEGMENTS;
    return SIW'(s);
  endfunction

  // memories
  logic [END_W-1:0] tb_mem [MAX_TRAINS];
  logic [END_W-1:0] te_mem [MAX_TRAINS];
  logic [SCW-1:0]   ts_mem [MAX_TRAINS];
  logic [SEQ_W-1:0] ss_mem [MAX_SEGMENTS];
  logic [LEN_W-1:0] sl_mem [MAX_SEGMENTS];

  logic [END_W-1:0] cur_b_r, cur_e_r;
  logic [SCW-1:0]   cur_s_r;
  logic [SEQ_W-1:0] sd_start_r;
  logic [LEN_W-1:0] sd_len_r;

  logic             t_we, t_re, s_we, s_re;
  logic [TIW-1:0]   t_waddr, t_raddr;
  logic [SIW-1:0]   s_waddr, s_raddr;
  logic [END_W-1:0] t_wb, t_wend;
  logic [SCW-1:0]   t_ws;
  logic [SEQ_W-1:0] s_wstart;
  logic [LEN_W-1:0] s_wlen;

  // item and list state
  logic             cmd_r;
  logic [SEQ_W-1:0] seq_r;
  logic [LEN_W-1:0] len_r;
  logic [END_W-1:0] a_r, b_r;
  logic             ok_r, full_r;
  logic [END_W-1:0] held_first_r, held_last_r;
  logic [TCW-1:0]   trains_r;
  logic [SCW-1:0]   segs_r;
  logic [TIW-1:0]   thead_r;
  logic [SIW-1:0]   shead_r;
  logic [TCW-1:0]   idx_r, kt_r;
  logic [SCW-1:0]   pos_r, ks_r;
  logic [END_W-1:0] prev_b_r, prev_e_r;
  logic [SCW-1:0]   prev_s_r;
  logic [END_W-1:0] rem_begin;

  assign rem_begin = cur_b_r + END_W'(sd_len_r);

  always_comb begin
    status.is_remove   = (cmd_r == CMD_REMOVE);
    status.len_zero    = (len_r == '0);
    status.trains_zero = (trains_r == '0);
    status.segs_full   = (segs_r >= SCW'(MAX_SEGMENTS));
    status.trains_full = (trains_r >= TCW'(MAX_TRAINS));
    status.a_eq_last   = (a_r == held_last_r);
    status.a_gt_last   = (a_r > held_last_r);
    status.overlap     = (b_r > cur_b_r) && (a_r < cur_e_r);
    status.below       = (b_r <= cur_b_r);
    status.scan_last   = (TCW'(idx_r + TCW'(1)) == trains_r);
    status.join_prev   = (idx_r != '0) && (a_r == prev_e_r);
    status.join_next   = (b_r == cur_b_r);
    status.tdel_done   = (TCW'(kt_r + TCW'(1)) >= trains_r);
    status.tins_done   = (kt_r == idx_r);
    status.sins_done   = (ks_r == pos_r);
    status.rem_empty   = (segs_r == '0) || (trains_r == '0);
    status.rem_del     = (cur_s_r == SCW'(1));
    status.rem_last    = (trains_r == TCW'(1));
  end

  // memory port steering
  always_comb begin
    t_we     = 1'b0;
    t_re     = 1'b0;
    s_we     = 1'b0;
    s_re     = 1'b0;
    t_waddr  = tphys(thead_r, int'(kt_r));
    t_raddr  = tphys(thead_r, 0);
    s_waddr  = sphys(shead_r, int'(ks_r));
    s_raddr  = sphys(shead_r, 0);
    t_wb     = cur_b_r;
    t_wend   = cur_e_r;
    t_ws     = cur_s_r;
    s_wstart = seq_r;
    s_wlen   = len_r;
    case (cmd.op)
      OP_INS_EMPTY: begin
        t_we    = 1'b1;
        t_waddr = tphys(thead_r, 0);
        t_wb    = a_r;
        t_wend  = b_r;
        t_ws    = SCW'(1);
        s_we    = 1'b1;
        s_waddr = sphys(shead_r, 0);
      end
      OP_RD_LAST: begin
        t_re    = 1'b1;
        t_raddr = tphys(thead_r, int'(trains_r) - 1);
      end
      OP_EXT_LAST: begin
        t_we    = 1'b1;
        t_waddr = tphys(thead_r, int'(trains_r) - 1);
        t_wend  = b_r;
        t_ws    = SCW'(cur_s_r + SCW'(1));
        s_we    = 1'b1;
        s_waddr = sphys(shead_r, int'(segs_r));
      end
      OP_APPEND: begin
        t_we    = 1'b1;
        t_waddr = tphys(thead_r, int'(trains_r));
        t_wb    = a_r;
        t_wend  = b_r;
        t_ws    = SCW'(1);
        s_we    = 1'b1;
        s_waddr = sphys(shead_r, int'(segs_r));
      end
      OP_SCAN_START: begin
        t_re    = 1'b1;
        t_raddr = tphys(thead_r, 0);
      end
      OP_SCAN_NEXT: begin
        t_re    = 1'b1;
        t_raddr = tphys(thead_r, int'(idx_r) + 1);
      end
      OP_JOIN_BOTH: begin
        t_we    = 1'b1;
        t_waddr = tphys(thead_r, int'(idx_r) - 1);
        t_wb    = prev_b_r;
        t_wend  = cur_e_r;
        t_ws    = SCW'(prev_s_r + cur_s_r + SCW'(1));
      end
      OP_JOIN_PREV: begin
        t_we    = 1'b1;
        t_waddr = tphys(thead_r, int'(idx_r) - 1);
        t_wb    = prev_b_r;
        t_wend  = b_r;
        t_ws    = SCW'(prev_s_r + SCW'(1));
      end
      OP_JOIN_NEXT: begin
        t_we    = 1'b1;
        t_waddr = tphys(thead_r, int'(idx_r));
        t_wb    = a_r;
        t_ws    = SCW'(cur_s_r + SCW'(1));
      end
      OP_TINS_READ: begin
        t_re    = 1'b1;
        t_raddr = tphys(thead_r, int'(kt_r) - 1);
      end
      OP_TINS_WRITE, OP_TDEL_WRITE: begin
        t_we    = 1'b1;
        t_waddr = tphys(thead_r, int'(kt_r));
      end
      OP_TINS_FIN: begin
        t_we    = 1'b1;
        t_waddr = tphys(thead_r, int'(idx_r));
        t_wb    = a_r;
        t_wend  = b_r;
        t_ws    = SCW'(1);
      end
      OP_TDEL_READ: begin
        t_re    = 1'b1;
        t_raddr = tphys(thead_r, int'(kt_r) + 1);
      end
      OP_SINS_READ: begin
        s_re    = 1'b1;
        s_raddr = sphys(shead_r, int'(ks_r) - 1);
      end
      OP_SINS_WRITE: begin
        s_we     = 1'b1;
        s_waddr  = sphys(shead_r, int'(ks_r));
        s_wstart = sd_start_r;
        s_wlen   = sd_len_r;
      end
      OP_SINS_FIN: begin
        s_we    = 1'b1;
        s_waddr = sphys(shead_r, int'(pos_r));
      end
      OP_REM_RD: begin
        t_re    = 1'b1;
        t_raddr = tphys(thead_r, 0);
        s_re    = 1'b1;
        s_raddr = sphys(shead_r, 0);
      end
      OP_REM_UPD: begin
        if (cur_s_r == SCW'(1)) begin
          // first train emptied, fetch the one behind it
          t_re    = 1'b1;
          t_raddr = tphys(thead_r, 1);
        end else begin
          t_we    = 1'b1;
          t_waddr = tphys(thead_r, 0);
          t_wb    = rem_begin;
          t_ws    = SCW'(cur_s_r - SCW'(1));
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (t_we) begin
      tb_mem[t_waddr] <= t_wb;
      te_mem[t_waddr] <= t_wend;
      ts_mem[t_waddr] <= t_ws;
    end
    if (t_re) begin
      cur_b_r <= tb_mem[t_raddr];
      cur_e_r <= te_mem[t_raddr];
      cur_s_r <= ts_mem[t_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (s_we) begin
      ss_mem[s_waddr] <= s_wstart;
      sl_mem[s_waddr] <= s_wlen;
    end
    if (s_re) begin
      sd_start_r <= ss_mem[s_raddr];
      sd_len_r   <= sl_mem[s_raddr];
    end
  end

  // list state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_first_r <= '0;
      held_last_r  <= '0;
      trains_r     <= '0;
      segs_r       <= '0;
      thead_r      <= '0;
      shead_r      <= '0;
    end else begin
      case (cmd.op)
        OP_INS_EMPTY: begin
          trains_r     <= TCW'(1);
          segs_r       <= SCW'(segs_r + SCW'(1));
          held_first_r <= a_r;
          held_last_r  <= b_r;
        end
        OP_EXT_LAST: begin
          segs_r      <= SCW'(segs_r + SCW'(1));
          held_last_r <= b_r;
        end
        OP_APPEND: begin
          trains_r    <= TCW'(trains_r + TCW'(1));
          segs_r      <= SCW'(segs_r + SCW'(1));
          held_last_r <= b_r;
        end
        OP_TINS_FIN: trains_r <= TCW'(trains_r + TCW'(1));
        OP_TDEL_FIN: trains_r <= TCW'(trains_r - TCW'(1));
        OP_SINS_FIN: begin
          segs_r <= SCW'(segs_r + SCW'(1));
          if (idx_r == '0) held_first_r <= a_r;
        end
        OP_REM_EMPTY: begin
          held_first_r <= '0;
          held_last_r  <= '0;
        end
        OP_REM_UPD: begin
          segs_r  <= SCW'(segs_r - SCW'(1));
          shead_r <= sphys(shead_r, 1);
          if (cur_s_r == SCW'(1)) begin
            thead_r  <= tphys(thead_r, 1);
            trains_r <= TCW'(trains_r - TCW'(1));
            if (trains_r == TCW'(1)) begin
              held_first_r <= '0;
              held_last_r  <= '0;
            end
          end else begin
            held_first_r <= rem_begin;
          end
        end
        OP_REM_FIRST: held_first_r <= cur_b_r;
        default: begin
        end
      endcase
    end
  end

  // per item scratch and result payload
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        cmd_r  <= in_command;
        seq_r  <= in_seg_start;
        len_r  <= in_seg_length;
        a_r    <= END_W'(in_seg_start);
        b_r    <= END_W'(in_seg_start) + END_W'(in_seg_length);
        ok_r   <= 1'b0;
        full_r <= 1'b0;
      end
      OP_FULL: full_r <= 1'b1;
      OP_INS_EMPTY, OP_EXT_LAST, OP_APPEND, OP_SINS_FIN, OP_REM_UPD: ok_r <= 1'b1;
      OP_SCAN_START: begin
        idx_r <= '0;
        pos_r <= '0;
      end
      OP_SCAN_NEXT: begin
        prev_b_r <= cur_b_r;
        prev_e_r <= cur_e_r;
        prev_s_r <= cur_s_r;
        pos_r    <= SCW'(pos_r + cur_s_r);
        idx_r    <= TCW'(idx_r + TCW'(1));
      end
      OP_JOIN_BOTH: kt_r <= idx_r;
      OP_TINS_START: kt_r <= trains_r;
      OP_JOIN_PREV, OP_JOIN_NEXT, OP_TINS_FIN, OP_TDEL_FIN: ks_r <= segs_r;
      OP_TINS_WRITE: kt_r <= TCW'(kt_r - TCW'(1));
      OP_TDEL_WRITE: kt_r <= TCW'(kt_r + TCW'(1));
      OP_SINS_WRITE: ks_r <= SCW'(ks_r - SCW'(1));
      OP_EMIT: begin
        out_ok            <= ok_r;
        out_full_res      <= full_r;
        out_list_first    <= held_first_r;
        out_list_last     <= held_last_r;
        out_train_count   <= TRAIN_CNT_OUT_W'(trains_r);
        out_segment_count <= SEG_CNT_OUT_W'(segs_r);
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/tstt_ctrl.sv =====
`default_nettype none
module tstt_ctrl
  import tstt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  wire logic        out_stall,
  output dp_cmd_t          cmd,
  input  wire dp_status_t  status
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_SCAN_CHK,
    S_TINS_RD,
    S_TINS_WR,
    S_TDEL_RD,
    S_TDEL_WR,
    S_SINS_RD,
    S_SINS_WR,
    S_EXT_LAST,
    S_REM_UPD,
    S_REM_FIRST,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_nxt = S_FINISH;
        if (status.is_remove) begin
          if (status.rem_empty) begin
            cmd.op = OP_REM_EMPTY;
          end else begin
            cmd.op    = OP_REM_RD;
            state_nxt = S_REM_UPD;
          end
        end else if (status.len_zero) begin
          cmd.op = OP_NONE;
        end else if (status.trains_zero) begin
          cmd.op = status.segs_full ? OP_FULL : OP_INS_EMPTY;
        end else if (status.a_eq_last) begin
          if (status.segs_full) begin
            cmd.op = OP_FULL;
          end else begin
            cmd.op    = OP_RD_LAST;
            state_nxt = S_EXT_LAST;
          end
        end else if (status.a_gt_last) begin
          cmd.op = (status.segs_full || status.trains_full) ? OP_FULL : OP_APPEND;
        end else begin
          cmd.op    = OP_SCAN_START;
          state_nxt = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        state_nxt = S_FINISH;
        if (status.overlap) begin
          cmd.op = OP_NONE;
        end else if (status.below) begin
          if (status.segs_full ||
              (!status.join_prev && !status.join_next && status.trains_full)) begin
            cmd.op = OP_FULL;
          end else if (status.join_prev && status.join_next) begin
            cmd.op    = OP_JOIN_BOTH;
            state_nxt = S_TDEL_RD;
          end else if (status.join_prev) begin
            cmd.op    = OP_JOIN_PREV;
            state_nxt = S_SINS_RD;
          end else if (status.join_next) begin
            cmd.op    = OP_JOIN_NEXT;
            state_nxt = S_SINS_RD;
          end else begin
            cmd.op    = OP_TINS_START;
            state_nxt = S_TINS_RD;
          end
        end else if (status.scan_last) begin
          // no train at or above the segment end
          cmd.op = OP_NONE;
        end else begin
          cmd.op    = OP_SCAN_NEXT;
          state_nxt = S_SCAN_CHK;
        end
      end
      S_TINS_RD: begin
        if (status.tins_done) begin
          cmd.op    = OP_TINS_FIN;
          state_nxt = S_SINS_RD;
        end else begin
          cmd.op    = OP_TINS_READ;
          state_nxt = S_TINS_WR;
        end
      end
      S_TINS_WR: begin
        cmd.op    = OP_TINS_WRITE;
        state_nxt = S_TINS_RD;
      end
      S_TDEL_RD: begin
        if (status.tdel_done) begin
          cmd.op    = OP_TDEL_FIN;
          state_nxt = S_SINS_RD;
        end else begin
          cmd.op    = OP_TDEL_READ;
          state_nxt = S_TDEL_WR;
        end
      end
      S_TDEL_WR: begin
        cmd.op    = OP_TDEL_WRITE;
        state_nxt = S_TDEL_RD;
      end
      S_SINS_RD: begin
        if (status.sins_done) begin
          cmd.op    = OP_SINS_FIN;
          state_nxt = S_FINISH;
        end else begin
          cmd.op    = OP_SINS_READ;
          state_nxt = S_SINS_WR;
        end
      end
      S_SINS_WR: begin
        cmd.op    = OP_SINS_WRITE;
        state_nxt = S_SINS_RD;
      end
      S_EXT_LAST: begin
        cmd.op    = OP_EXT_LAST;
        state_nxt = S_FINISH;
      end
      S_REM_UPD: begin
        cmd.op    = OP_REM_UPD;
        state_nxt = (status.rem_del && !status.rem_last) ? S_REM_FIRST : S_FINISH;
      end
      S_REM_FIRST: begin
        cmd.op    = OP_REM_FIRST;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (!(out_valid_r && out_stall)) begin
          cmd.op    = OP_EMIT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.op == OP_EMIT) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/tcp_segment_train_tracker.sv =====
// tcp segment train tracker
// input channel: in_valid / in_stall with in_command (insert or remove lowest),
// in_seg_start and in_seg_length. a beat is taken when in_valid is high and
// in_stall is low; in_stall is high while an item is being worked on.
// result channel: out_valid / out_stall, one result beat per input beat, held
// steady while out_stall is high. a finished result sits in the output
// register, so the next input beat is taken while it waits.
// each item runs from the accept back to idle as load, decide, the steps
// below and emit, paced by the single ported train and segment memories:
//   remove: an update unless the list is empty, and a first bound step when
//   the first train empties and another follows; insert rejected early,
//   starting, appending or extending: an extend step only when extending;
//   insert into the middle: a scan step per train scanned, a store step, a
//   step when trains move, a read and a write per train and segment moved
// reset empties the list: all counts and bounds go to zero, no memory
// clearing pass is needed since only held entries are ever read.
// out_stall only holds the result; a new item can start meanwhile and waits
// in its final state until the output register is free.
`default_nettype none
module tcp_segment_train_tracker
  import tstt_pkg::*;
#(
  parameter int MAX_SEGMENTS = 64,
  parameter int MAX_TRAINS = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        in_command,
  input  wire logic [SEQ_W-1:0]            in_seg_start,
  input  wire logic [LEN_W-1:0]            in_seg_length,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             out_ok,
  output logic [END_W-1:0]                 out_list_first,
  output logic [END_W-1:0]                 out_list_last,
  output logic [TRAIN_CNT_OUT_W-1:0]       out_train_count,
  output logic [SEG_CNT_OUT_W-1:0]         out_segment_count,
  output logic                             out_full_res
);

  dp_cmd_t    cmd;
  dp_status_t status;

  tstt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  tstt_datapath #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .MAX_TRAINS   (MAX_TRAINS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .in_command        (in_command),
    .in_seg_start      (in_seg_start),
    .in_seg_length     (in_seg_length),
    .out_ok            (out_ok),
    .out_list_first    (out_list_first),
    .out_list_last     (out_list_last),
    .out_train_count   (out_train_count),
    .out_segment_count (out_segment_count),
    .out_full_res      (out_full_res)
  );

endmodule
`default_nettype wire
